// ----- hw/rtl/skrt_pkg.sv -----
package skrt_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned KeyWidth     = 32;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOCATE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2,
    ST_ZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [KeyWidth-1:0] key;
    logic signed [KeyWidth-1:0] page;
    logic signed [KeyWidth-1:0] slot;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp_en;
    logic wr_en;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/sorted_key_record_table.sv -----
// Sorted key/record table built as a chain of DEPTH cells, one entry per cell,
// kept in ascending signed key order. At the accepting edge all cells compare
// their key against the request key at once; then, in the execution state and
// once the output is free, the position is encoded from the cell flags, an
// insert shifts the cells at and above that position up by one, and the result
// is registered. A new request is taken while a finished result still waits on
// the output, but not while the previous one is still in execution. The cell
// storage needs no clearing after reset; it and the result registers are not reset.
module sorted_key_record_table #(
  parameter int unsigned DEPTH = skrt_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           req_type_i,
  input  logic signed [skrt_pkg::KeyWidth-1:0] key_i,
  input  logic signed [skrt_pkg::KeyWidth-1:0] record_page_i,
  input  logic signed [skrt_pkg::KeyWidth-1:0] record_slot_i,
  input  logic [6:0]                           entry_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic [6:0]                           position_o,
  output logic signed [skrt_pkg::KeyWidth-1:0] found_key_o,
  output logic signed [skrt_pkg::KeyWidth-1:0] found_page_o,
  output logic signed [skrt_pkg::KeyWidth-1:0] found_slot_o,
  output logic [6:0]                           entry_count_o
);
  import skrt_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  typedef struct packed {
    req_type_e   req_type;
    entry_t      item;
    logic [6:0]  entry_index;
  } req_t;

  state_e          state_q, state_d;
  req_t            req_q;
  logic [CW-1:0]   count_q, count_d;
  logic            in_accept;
  logic            out_free;
  cell_ctrl_t      ctrl;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] lt;
  logic [DEPTH-1:0] eq;
  logic [DEPTH-1:0] prev_lt;
  entry_t           entries [DEPTH];

  logic [CW-1:0]   pos;
  logic [CW-1:0]   cand;
  logic            hit;
  logic            rd_ok;
  logic [IW-1:0]   rd_idx;
  logic            ins_ok;

  status_e         status_d;
  logic [CW-1:0]   pos_d;
  entry_t          found_d;

  logic            out_valid_q;
  status_e         status_q;
  logic [6:0]      position_q;
  entry_t          found_q;
  logic [6:0]      entry_count_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ctrl.cmp_en = in_accept;
  assign ctrl.wr_en  = (state_q == S_EXEC) && out_free && ins_ok;

  assign prev_lt = {lt[DEPTH-2:0], 1'b1};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = CW'(i) < count_q;

    skrt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .search_key_i (key_i),
      .new_i        (req_q.item),
      .prev_i       ((i == 0) ? req_q.item : entries[(i == 0) ? 0 : i - 1]),
      .prev_lt_i    (prev_lt[i]),
      .lt_o         (lt[i]),
      .eq_o         (eq[i]),
      .entry_o      (entries[i])
    );
  end

  // The less-than flags form a run of ones from cell zero, so the position is
  // the length of that run, found one bit at a time from the top.
  always_comb begin
    pos  = '0;
    cand = '0;
    for (int b = CW - 1; b >= 0; b--) begin
      cand = pos | (CW'(1) << b);
      if (cand <= CW'(DEPTH) && lt[IW'(cand - 1'b1)]) begin
        pos = cand;
      end
    end
  end

  assign hit    = |(eq & ~lt & prev_lt);
  assign rd_ok  = XW'(req_q.entry_index) < XW'(count_q);
  assign rd_idx = IW'(req_q.entry_index);
  assign ins_ok = (req_q.req_type == REQ_INSERT) && (req_q.item.key != '0)
                  && (count_q < CW'(DEPTH));

  always_comb begin
    status_d = ST_NONE;
    pos_d    = '0;
    found_d  = '0;
    count_d  = count_q;
    unique case (req_q.req_type)
      REQ_INSERT: begin
        if (req_q.item.key == '0) begin
          status_d = ST_ZERO;
        end else if (!ins_ok) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          pos_d    = pos;
          count_d  = CW'(count_q + 1'b1);
        end
      end
      REQ_LOCATE: begin
        pos_d    = pos;
        status_d = hit ? ST_OK : ST_NONE;
      end
      REQ_READ: begin
        if (rd_ok) begin
          status_d = ST_OK;
          found_d  = entries[rd_idx];
        end
      end
      REQ_UNUSED: begin
        status_d = ST_NONE;
      end
      default: status_d = ST_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC && out_free) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q.req_type    <= req_type_e'(req_type_i);
      req_q.item.key    <= key_i;
      req_q.item.page   <= record_page_i;
      req_q.item.slot   <= record_slot_i;
      req_q.entry_index <= entry_index_i;
    end
    if (state_q == S_EXEC && out_free) begin
      status_q      <= status_d;
      position_q    <= 7'(pos_d);
      found_q       <= found_d;
      entry_count_q <= 7'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = position_q;
  assign found_key_o   = found_q.key;
  assign found_page_o  = found_q.page;
  assign found_slot_o  = found_q.slot;
  assign entry_count_o = entry_count_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count exceeds table depth");

  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_EXEC)
    else $error("accepted transaction did not enter execution");

  a_sorted_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> ((({1'b0, lt} + 1'b1) & {1'b0, lt}) == '0))
    else $error("less-than flags are not a run from cell zero");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == CW'($past(count_q) + 1'b1))
    else $error("entry count changed by other than one");

  a_write_only_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> out_free && state_q == S_EXEC)
    else $error("cells shifted outside execution");

endmodule

// ----- hw/rtl/skrt_cell.sv -----
module skrt_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  skrt_pkg::cell_ctrl_t                   ctrl_i,
  input  logic                                   occ_i,
  input  logic signed [skrt_pkg::KeyWidth-1:0]   search_key_i,
  input  skrt_pkg::entry_t                       new_i,
  input  skrt_pkg::entry_t                       prev_i,
  input  logic                                   prev_lt_i,
  output logic                                   lt_o,
  output logic                                   eq_o,
  output skrt_pkg::entry_t                       entry_o
);
  import skrt_pkg::*;

  entry_t entry_q, entry_d;
  logic   lt_q, lt_d;
  logic   eq_q, eq_d;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      lt_d = occ_i && (entry_q.key < search_key_i);
      eq_d = occ_i && (entry_q.key == search_key_i);
    end
  end

  // A cell whose key is still below the new one keeps its entry. The first cell
  // that is not below takes the new entry, and every later cell takes the entry
  // of its lower neighbor.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.wr_en && !lt_q) begin
      if (prev_lt_i) begin
        entry_d = new_i;
      end else begin
        entry_d = prev_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign entry_o = entry_q;

endmodule
